// ===== sv/dbat_pkg.sv =====
// Package for the double-byte aware tokenizer: result and queue entry types,
// configuration register indexes and the lead byte ranges. No dependencies.
package dbat_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENCODING_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_A     = 3'd2;

    localparam logic MODE_EUC  = 1'b0;
    localparam logic MODE_SJIS = 1'b1;

    localparam logic [7:0] SJIS_LEAD_LO1 = 8'h81;
    localparam logic [7:0] SJIS_LEAD_HI1 = 8'h9f;
    localparam logic [7:0] SJIS_LEAD_LO2 = 8'he0;
    localparam logic [7:0] SJIS_LEAD_HI2 = 8'hfc;
    localparam logic [7:0] EUC_LEAD_LO   = 8'ha1;
    localparam logic [7:0] EUC_LEAD_HI   = 8'hfe;
    localparam logic [7:0] EUC_SS2       = 8'h8e;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       marker;
    } res_t;

    typedef struct packed {
        logic [1:0]             count;
        res_t [MAX_RESULTS-1:0] res;
    } entry_t;

    function automatic logic is_lead(input logic mode, input logic [7:0] b);
        if (mode == MODE_SJIS)
        begin
            return ((b >= SJIS_LEAD_LO1) && (b <= SJIS_LEAD_HI1)) ||
                   ((b >= SJIS_LEAD_LO2) && (b <= SJIS_LEAD_HI2));
        end
        return ((b >= EUC_LEAD_LO) && (b <= EUC_LEAD_HI)) || (b == EUC_SS2);
    endfunction

endpackage

// ===== sv/double_byte_aware_tokenizer.sv =====
// Top level of the double-byte aware tokenizer.
// Depends on dbat_pkg, dbat_front, dbat_fifo and dbat_back.
//
// Text bytes enter on the input channel (in_valid/in_ready) one item at a
// time, with end_of_string on the final byte. Results leave on the output
// channel (out_valid/out_ready): token bytes with token_first on the first
// byte of each token, end-of-token items with token_end set, and run_last
// on the last result caused by one input item.
// The front end accepts one item per cycle while the queue is not full and
// turns it into a group of zero to three results; the back end sends one
// result per cycle while out_ready is high. A lead byte produces nothing
// until its trail byte arrives, unless it carries end_of_string. Sustained
// rate is one input item per cycle while groups have one result and the
// receiver is ready, and a four-entry queue absorbs larger groups. When the
// receiver stalls, results wait in the queue and in_ready drops only once
// the queue is full. Configuration is written through cfg_write, cfg_index
// and cfg_data, by the user only while the block is idle, which the block
// does not enforce. Reset clears configuration, token state and the queue.
module double_byte_aware_tokenizer #(
    parameter int SEPARATOR_SLOTS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [dbat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbat_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             end_of_string,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             token_first,
    output logic                             token_end,
    output logic                             run_last
);
    import dbat_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   head_valid;
    entry_t push_entry;
    entry_t head_entry;

    dbat_front #(
        .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    dbat_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    dbat_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .token_first (token_first),
        .token_end   (token_end),
        .run_last    (run_last)
    );

endmodule

// ===== sv/dbat_front.sv =====
// Front end of the tokenizer: configuration registers, character assembly,
// separator matching and token state. Builds one queue entry per item that yields results.
// Depends on dbat_pkg.
module dbat_front #(
    parameter int SEPARATOR_SLOTS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dbat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbat_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            end_of_string,
    input  logic                            q_full,
    output logic                            q_push,
    output dbat_pkg::entry_t                q_entry
);
    import dbat_pkg::*;

    localparam logic [2:0] SLOTS_W = 3'(SEPARATOR_SLOTS);

    logic        mode_reg;
    logic [2:0]  count_reg;
    logic [15:0] sep_reg [SEPARATOR_SLOTS];

    logic [7:0]  held_reg, held_next;
    logic        pend_reg, pend_next;
    logic        inside_reg, inside_next;

    logic        accept;
    logic [2:0]  n_sat;
    entry_t      ent;

    function automatic logic match_sep(input logic [15:0] ch, input logic [2:0] n,
                                       input logic [15:0] seps [SEPARATOR_SLOTS]);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SEPARATOR_SLOTS; i++)
        begin
            if ((3'(i) < n) && (seps[i] != 16'h0) && (seps[i] == ch))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_EUC;
            count_reg <= '0;
            for (int i = 0; i < SEPARATOR_SLOTS; i++)
            begin
                sep_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ENCODING_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_SEPARATOR_COUNT)
            begin
                count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < SEPARATOR_SLOTS; i++)
            begin
                if (cfg_index == CFG_SEPARATOR_A + 3'(i))
                begin
                    sep_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign n_sat    = (count_reg > SLOTS_W) ? SLOTS_W : count_reg;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [1:0] cnt;
        logic       ins;
        ent         = '0;
        cnt         = 2'd0;
        ins         = inside_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        if (pend_reg)
        begin
            pend_next = 1'b0;
            held_next = 8'h0;
            if (match_sep({held_reg, data_byte}, n_sat, sep_reg))
            begin
                if (ins)
                begin
                    ent.res[cnt] = '{data: 8'h0, first: 1'b0, marker: 1'b1};
                    cnt          = cnt + 2'd1;
                end
                ins = 1'b0;
            end
            else
            begin
                ent.res[cnt] = '{data: held_reg, first: !ins, marker: 1'b0};
                cnt          = cnt + 2'd1;
                ent.res[cnt] = '{data: data_byte, first: 1'b0, marker: 1'b0};
                cnt          = cnt + 2'd1;
                ins          = 1'b1;
            end
        end
        else if (is_lead(mode_reg, data_byte))
        begin
            if (end_of_string)
            begin
                ent.res[cnt] = '{data: data_byte, first: !ins, marker: 1'b0};
                cnt          = cnt + 2'd1;
                ins          = 1'b1;
            end
            else
            begin
                held_next = data_byte;
                pend_next = 1'b1;
            end
        end
        else if (match_sep({8'h0, data_byte}, n_sat, sep_reg))
        begin
            if (ins)
            begin
                ent.res[cnt] = '{data: 8'h0, first: 1'b0, marker: 1'b1};
                cnt          = cnt + 2'd1;
            end
            ins = 1'b0;
        end
        else
        begin
            ent.res[cnt] = '{data: data_byte, first: !ins, marker: 1'b0};
            cnt          = cnt + 2'd1;
            ins          = 1'b1;
        end
        if (end_of_string)
        begin
            if (ins)
            begin
                ent.res[cnt] = '{data: 8'h0, first: 1'b0, marker: 1'b1};
                cnt          = cnt + 2'd1;
            end
            ins       = 1'b0;
            pend_next = 1'b0;
            held_next = 8'h0;
        end
        ent.count   = cnt;
        inside_next = ins;
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            pend_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            pend_reg   <= pend_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ===== sv/dbat_fifo.sv =====
// Short queue of result groups between the front and back ends.
// Depends on dbat_pkg.
module dbat_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dbat_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output dbat_pkg::entry_t head_entry
);
    import dbat_pkg::*;

    entry_t                mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_reg;
    logic [QPTR_W-1:0]     rd_reg;
    logic [QCOUNT_W-1:0]   cnt_reg;

    assign full       = (cnt_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCOUNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCOUNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/dbat_back.sv =====
// Back end of the tokenizer: walks the results of the queue head one per
// cycle while out_ready is high and drives the output channel. Depends on dbat_pkg.
module dbat_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  dbat_pkg::entry_t head_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             token_first,
    output logic             token_end,
    output logic             run_last
);
    import dbat_pkg::*;

    logic [1:0] k_reg;
    logic       last;
    res_t       cur;

    assign cur         = head_entry.res[k_reg];
    assign last        = ((k_reg + 2'd1) == head_entry.count);
    assign out_valid   = head_valid;
    assign out_byte    = cur.data;
    assign token_first = cur.first;
    assign token_end   = cur.marker;
    assign run_last    = last;
    assign pop         = head_valid && out_ready && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (head_valid && out_ready)
        begin
            k_reg <= last ? 2'd0 : k_reg + 2'd1;
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_entry.count != 2'd0))
        else $error("queue head holds an empty group");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (k_reg < head_entry.count))
        else $error("result index past the group size");

    a_index_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 2'd0) |-> head_valid)
        else $error("group walk in progress without a queue head");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_byte_aware_tokenizer, built on dbat_pkg.
// A directed table and random texts are checked against a behavioral
// tokenizer model under random idling and a long receiver stall.
module tb_top;

    import dbat_pkg::*;

    localparam int SEPARATOR_SLOTS      = 4;
    localparam int SETTLE_CYCLES        = 8;
    localparam int RECEIVER_HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT          = 200000;

    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_B = CFG_SEPARATOR_A + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_C = CFG_SEPARATOR_A + 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_D = CFG_SEPARATOR_A + 3'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       marker;
        logic       last;
    } token_out_t;

    typedef enum logic [1:0] {ROW_PLAIN, ROW_TYPED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [15:0]            value;
        logic                   eos;
        logic [1:0]             count;
        token_out_t             head;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             data_byte;
    logic                   end_of_string;
    logic                   out_valid;
    logic                   out_ready;
    logic [7:0]             out_byte;
    logic                   token_first;
    logic                   token_end;
    logic                   run_last;

    logic        tok_mode;
    logic [2:0]  tok_sep_count;
    logic [15:0] tok_seps [SEPARATOR_SLOTS];
    logic [7:0]  held_byte;
    logic        pair_open;
    logic        in_token;

    token_out_t step_res [MAX_RESULTS];
    int         step_n;
    token_out_t expected_tokens [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_request   = 1'b0;

    double_byte_aware_tokenizer #(
        .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .end_of_string(end_of_string),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .token_first(token_first),
        .token_end(token_end),
        .run_last(run_last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic starts_pair(input logic [7:0] b);
        if (tok_mode == MODE_SJIS)
        begin
            return ((b >= SJIS_LEAD_LO1) && (b <= SJIS_LEAD_HI1)) ||
                   ((b >= SJIS_LEAD_LO2) && (b <= SJIS_LEAD_HI2));
        end
        return ((b >= EUC_LEAD_LO) && (b <= EUC_LEAD_HI)) || (b == EUC_SS2);
    endfunction

    function automatic logic matches_separator(input logic [15:0] ch);
        int in_use;
        in_use = (tok_sep_count > SEPARATOR_SLOTS) ? SEPARATOR_SLOTS : tok_sep_count;
        for (int i = 0; i < in_use; i++)
        begin
            if ((tok_seps[i] != 16'h0000) && (tok_seps[i] == ch))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_token_byte(input logic [7:0] b);
        step_res[step_n] = {b, ~in_token, 1'b0, 1'b0};
        step_n++;
        in_token = 1'b1;
    endfunction

    function automatic void close_token();
        if (in_token)
        begin
            step_res[step_n] = {8'h00, 1'b0, 1'b1, 1'b0};
            step_n++;
        end
        in_token = 1'b0;
    endfunction

    // Advances the tokenizer state by one text byte and queues the results it causes.
    function automatic int tokenize_byte(input logic [7:0] b, input logic eos);
        step_n = 0;
        if (pair_open)
        begin
            pair_open = 1'b0;
            if (matches_separator({held_byte, b}))
                close_token();
            else
            begin
                add_token_byte(held_byte);
                add_token_byte(b);
            end
            held_byte = 8'h00;
        end
        else if (starts_pair(b))
        begin
            if (eos)
                add_token_byte(b);
            else
            begin
                held_byte = b;
                pair_open = 1'b1;
            end
        end
        else if (matches_separator({8'h00, b}))
            close_token();
        else
            add_token_byte(b);
        if (eos)
        begin
            close_token();
            pair_open = 1'b0;
            held_byte = 8'h00;
        end
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_tokens.push_back(step_res[i]);
        return step_n;
    endfunction

    function automatic logic [7:0] random_byte(input logic want_lead);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (starts_pair(b) != want_lead);
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h, cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic eos, output int produced);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        produced = tokenize_byte(b, eos);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            CFG_ENCODING_MODE:   tok_mode = val[0];
            CFG_SEPARATOR_COUNT: tok_sep_count = val[2:0];
            default:             tok_seps[2'(idx - CFG_SEPARATOR_A)] = val;
        endcase
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Sends random texts, mostly built from separators, pairs and plain bytes of the
    // current mode, under a fresh configuration every sixty or so items.
    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input int target, input bit long_hold);
        logic [7:0]  text [$];
        logic [7:0]  trail;
        logic [15:0] sep;
        int          sent;
        int          since_config;
        int          roll;
        int          produced;
        sent          = 0;
        since_config  = 1000;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < target)
        begin
            if (since_config >= 60)
            begin
                settle();
                write_register(CFG_ENCODING_MODE, 16'($urandom_range(0, 1)));
                if ($urandom_range(0, 9) == 0)
                    write_register(CFG_SEPARATOR_COUNT, 16'($urandom_range(0, 7)));
                else
                    write_register(CFG_SEPARATOR_COUNT, 16'($urandom_range(1, 4)));
                for (int s = 0; s < SEPARATOR_SLOTS; s++)
                begin
                    roll  = $urandom_range(0, 9);
                    trail = 8'($urandom_range(0, 255));
                    if (roll < 4)
                        sep = {8'h00, random_byte(1'b0)};
                    else if (roll < 8)
                        sep = {random_byte(1'b1), trail};
                    else if (roll < 9)
                        sep = 16'($urandom_range(0, 65535));
                    else
                        sep = 16'h0000;
                    write_register(CFG_SEPARATOR_A + 3'(s), sep);
                end
                since_config = 0;
                if (long_hold)
                begin
                    hold_request = 1'b1;
                    long_hold    = 1'b0;
                end
            end
            text.delete();
            repeat ($urandom_range(1, 10))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                begin
                    sep = tok_seps[2'($urandom_range(0, SEPARATOR_SLOTS - 1))];
                    if (sep[15:8] != 8'h00)
                        text.push_back(sep[15:8]);
                    text.push_back(sep[7:0]);
                end
                else if (roll < 55)
                begin
                    trail = 8'($urandom_range(0, 255));
                    text.push_back(random_byte(1'b1));
                    text.push_back(trail);
                end
                else if (roll < 92)
                    text.push_back(random_byte(1'b0));
                else
                begin
                    trail = 8'($urandom_range(0, 255));
                    text.push_back(trail);
                end
            end
            if ($urandom_range(0, 9) == 0)
                text.push_back(random_byte(1'b1));
            foreach (text[i])
                offer_byte(text[i], i == text.size() - 1, produced);
            sent         += text.size();
            since_config += text.size();
        end
    endtask

    function automatic stim_row_t plain_row(input logic [7:0] b, input logic eos);
        return {ROW_PLAIN, 3'd0, {8'h00, b}, eos, 2'd0, 11'd0};
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] b, input logic eos,
                                            input logic [1:0] n, input token_out_t head);
        return {ROW_TYPED, 3'd0, {8'h00, b}, eos, n, head};
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [15:0] val);
        return {ROW_REG, idx, val, 1'b0, 2'd0, 11'd0};
    endfunction

    always @(posedge clk)
    begin : check_results
        token_out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("result with nothing expected", out_byte, 0);
            else
            begin
                want = expected_tokens.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (token_first !== want.first)
                    report_mismatch("token_first", token_first, want.first);
                if (token_end !== want.marker)
                    report_mismatch("token_end", token_end, want.marker);
                if (run_last !== want.last)
                    report_mismatch("run_last", run_last, want.last);
            end
        end
    end

    initial
    begin : receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (RECEIVER_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        stim_row_t directed [$];
        bit        regs_open;
        int        produced;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        end_of_string = 1'b0;
        tok_mode      = MODE_EUC;
        tok_sep_count = 3'd0;
        for (int i = 0; i < SEPARATOR_SLOTS; i++)
            tok_seps[i] = 16'h0000;
        held_byte = 8'h00;
        pair_open = 1'b0;
        in_token  = 1'b0;
        regs_open = 1'b0;

        directed.push_back(typed_row(8'h41, 1'b0, 2'd1, {8'h41, 1'b1, 1'b0, 1'b1}));
        directed.push_back(plain_row(8'h00, 1'b0));
        directed.push_back(typed_row(8'hff, 1'b1, 2'd2, {8'hff, 1'b0, 1'b0, 1'b0}));
        directed.push_back(reg_row(CFG_ENCODING_MODE, {15'd0, MODE_SJIS}));
        directed.push_back(reg_row(CFG_SEPARATOR_COUNT, 16'd7));
        directed.push_back(reg_row(CFG_SEPARATOR_A, 16'h002c));
        directed.push_back(reg_row(REG_SEPARATOR_B, 16'h8140));
        directed.push_back(reg_row(REG_SEPARATOR_C, 16'h0081));
        directed.push_back(reg_row(REG_SEPARATOR_D, 16'h0000));
        directed.push_back(typed_row(8'h2c, 1'b0, 2'd0, 11'd0));
        directed.push_back(plain_row(8'h61, 1'b0));
        directed.push_back(typed_row(8'h2c, 1'b0, 2'd1, {8'h00, 1'b0, 1'b1, 1'b1}));
        directed.push_back(typed_row(8'h2c, 1'b0, 2'd0, 11'd0));
        directed.push_back(typed_row(8'h81, 1'b0, 2'd0, 11'd0));
        directed.push_back(plain_row(8'h40, 1'b0));
        directed.push_back(plain_row(8'h62, 1'b0));
        directed.push_back(plain_row(8'h81, 1'b0));
        directed.push_back(typed_row(8'h40, 1'b0, 2'd1, {8'h00, 1'b0, 1'b1, 1'b1}));
        directed.push_back(plain_row(8'h81, 1'b0));
        directed.push_back(plain_row(8'h81, 1'b0));
        directed.push_back(plain_row(8'h00, 1'b0));
        directed.push_back(plain_row(8'he0, 1'b0));
        directed.push_back(plain_row(8'h00, 1'b0));
        directed.push_back(typed_row(8'hfc, 1'b1, 2'd2, {8'hfc, 1'b0, 1'b0, 1'b0}));
        directed.push_back(reg_row(CFG_ENCODING_MODE, {15'd0, MODE_EUC}));
        directed.push_back(reg_row(CFG_SEPARATOR_COUNT, 16'd4));
        directed.push_back(reg_row(CFG_SEPARATOR_A, 16'h8140));
        directed.push_back(reg_row(REG_SEPARATOR_B, 16'h00a1));
        directed.push_back(reg_row(REG_SEPARATOR_C, 16'ha1a1));
        directed.push_back(reg_row(REG_SEPARATOR_D, 16'hffff));
        directed.push_back(plain_row(8'h81, 1'b0));
        directed.push_back(plain_row(8'h40, 1'b0));
        directed.push_back(plain_row(8'h8e, 1'b0));
        directed.push_back(plain_row(8'ha1, 1'b0));
        directed.push_back(plain_row(8'ha1, 1'b0));
        directed.push_back(typed_row(8'ha1, 1'b1, 2'd1, {8'h00, 1'b0, 1'b1, 1'b1}));
        directed.push_back(typed_row(8'hfe, 1'b1, 2'd2, {8'hfe, 1'b1, 1'b0, 1'b0}));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 58;
        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_REG)
            begin
                if (!regs_open)
                    settle();
                regs_open = 1'b1;
                write_register(directed[r].index, directed[r].value);
            end
            else
            begin
                regs_open = 1'b0;
                offer_byte(directed[r].value[7:0], directed[r].eos, produced);
                if (directed[r].kind == ROW_TYPED)
                begin
                    if (produced != directed[r].count)
                        report_mismatch("result count", produced, directed[r].count);
                    else if ((produced > 0) && (step_res[0] != directed[r].head))
                        report_mismatch("first result", step_res[0], directed[r].head);
                end
            end
        end

        run_random_phase(13, 58, 120, 1'b0);
        run_random_phase(58, 13, 120, 1'b0);
        run_random_phase(0, 0, 110, 1'b1);

        settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
